>>> rtl/core/cwgf_pkg.sv
// ----------------------------------------------------------------------------
// cwgf_pkg
// Shared types and constants for the conducting wall ghost field unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cwgf_pkg;

	localparam int FIELD_WIDTH  = 32;
	localparam int NORMAL_WIDTH = 24;
	localparam int UNIT_FRAC    = 30;              // unit normal is Q2.30
	localparam int MAG_W        = UNIT_FRAC + 1;   // normalized magnitude width
	localparam int SQ_W         = 2 * MAG_W + 2;   // sum of three squares
	localparam int ROOT_W       = SQ_W / 2;
	localparam int QUO_W        = UNIT_FRAC + 1;
	localparam int UNIT_W       = UNIT_FRAC + 2;

	typedef struct packed {
		logic signed [NORMAL_WIDTH-1:0] normal_x;
		logic signed [NORMAL_WIDTH-1:0] normal_y;
		logic signed [NORMAL_WIDTH-1:0] normal_z;
		logic signed [FIELD_WIDTH-1:0]  inner_bx;
		logic signed [FIELD_WIDTH-1:0]  inner_by;
		logic signed [FIELD_WIDTH-1:0]  inner_bz;
		logic signed [FIELD_WIDTH-1:0]  inner_ex;
		logic signed [FIELD_WIDTH-1:0]  inner_ey;
		logic signed [FIELD_WIDTH-1:0]  inner_ez;
	} face_t;

	typedef struct packed {
		logic signed [FIELD_WIDTH-1:0] ghost_bx;
		logic signed [FIELD_WIDTH-1:0] ghost_by;
		logic signed [FIELD_WIDTH-1:0] ghost_bz;
		logic signed [FIELD_WIDTH-1:0] ghost_ex;
		logic signed [FIELD_WIDTH-1:0] ghost_ey;
		logic signed [FIELD_WIDTH-1:0] ghost_ez;
		logic                          zero_normal;
	} ghost_t;

	// Data that rides along the root and divide stages.
	typedef struct packed {
		logic                         zero;
		logic [2:0]                   neg;
		logic [2:0][MAG_W-1:0]        mag;
		logic [5:0][FIELD_WIDTH-1:0]  fld;
	} side_t;

endpackage

`default_nettype wire

>>> rtl/core/conducting_wall_ghost_fields_unit.sv
// ----------------------------------------------------------------------------
// conducting_wall_ghost_fields_unit
// Ghost B and E for a perfectly conducting wall face: normalize the face
// normal, mirror B about the wall and reflect E with its normal part kept.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  face    | in  | face_valid/stall     | face_t  (normal, inner B, inner E)
//  ghost   | out | ghost_valid/stall    | ghost_t (ghost B, ghost E, flag)
//
//  One face per cycle enters while the output is not stalled; depth is set by the one-bit-per-
//  stage square root (32 stages) and the three parallel dividers (31 stages).
//  All stages advance together whenever the output register is empty or taken.
//  Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module conducting_wall_ghost_fields_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            face_valid,
	output logic                 face_stall,
	input  wire cwgf_pkg::face_t face,
	output logic                 ghost_valid,
	input  wire logic            ghost_stall,
	output cwgf_pkg::ghost_t     ghost
);

	localparam int FW      = cwgf_pkg::FIELD_WIDTH;
	localparam int NW      = cwgf_pkg::NORMAL_WIDTH;
	localparam int UF      = cwgf_pkg::UNIT_FRAC;
	localparam int MW      = cwgf_pkg::MAG_W;
	localparam int SW      = cwgf_pkg::SQ_W;
	localparam int RW      = cwgf_pkg::ROOT_W;
	localparam int QW      = cwgf_pkg::QUO_W;
	localparam int UW      = cwgf_pkg::UNIT_W;
	localparam int PW      = $clog2(2 * MW);       // shift amount width
	localparam int WW      = 4 * MW;               // normalize window
	localparam int NUM_W   = MW + UF + 1;
	localparam int P1_W    = FW + UW;
	localparam int ACC_W   = P1_W + 2;
	localparam int D_W     = ACC_W - UF;
	localparam int P2_W    = D_W + UW;
	localparam int C_W     = P2_W - (UF - 1);
	localparam int G_W     = C_W + 1;

	logic adv;
	assign adv        = !ghost_valid || !ghost_stall;
	assign face_stall = !adv;

	// ---------------- stage 1: magnitudes and common OR ----------------
	logic [2:0][NW-1:0] nrm_in;
	logic [5:0][FW-1:0] fld_in;
	assign nrm_in = {face.normal_z, face.normal_y, face.normal_x};
	assign fld_in = {face.inner_ez, face.inner_ey, face.inner_ex,
		face.inner_bz, face.inner_by, face.inner_bx};

	logic               vld_s1;
	logic [2:0]         neg_s1;
	logic [2:0][NW-1:0] mag_s1;
	logic [NW-1:0]      orv_s1;
	logic [5:0][FW-1:0] fld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= face_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= nrm_in[i][NW-1];
				mag_s1[i] <= nrm_in[i][NW-1] ? (~nrm_in[i] + NW'(1)) : nrm_in[i];
			end
			orv_s1 <= (nrm_in[0][NW-1] ? (~nrm_in[0] + NW'(1)) : nrm_in[0])
				| (nrm_in[1][NW-1] ? (~nrm_in[1] + NW'(1)) : nrm_in[1])
				| (nrm_in[2][NW-1] ? (~nrm_in[2] + NW'(1)) : nrm_in[2]);
			fld_s1 <= fld_in;
		end
	end

	// ---------------- stage 2: leading bit of the largest magnitude ----------
	logic [PW-1:0] top_pos;
	always_comb begin
		top_pos = '0;
		for (int b = 0; b < NW; b++) begin
			if (orv_s1[b]) top_pos = PW'(b);
		end
	end

	logic               vld_s2;
	logic               zero_s2;
	logic [PW-1:0]      sh_s2;
	logic [2:0]         neg_s2;
	logic [2:0][NW-1:0] mag_s2;
	logic [5:0][FW-1:0] fld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s2 <= (orv_s1 == '0);
			sh_s2   <= PW'(2 * MW - 1) - top_pos;
			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			fld_s2  <= fld_s1;
		end
	end

	// ---------------- stage 3: shift so the largest lands at bit UF ----------
	// The top bit lands at bit 2*MW-1 of the window; taking the MW bits from
	// there down also truncates a magnitude whose top bit is one too high.
	logic [2:0][WW-1:0] win;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win[i] = WW'(mag_s2[i]) << sh_s2;
		end
	end

	logic    vld_s3;
	cwgf_pkg::side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3.zero <= zero_s2;
			side_s3.neg  <= neg_s2;
			for (int i = 0; i < 3; i++) begin
				side_s3.mag[i] <= win[i][2*MW-1:MW];
			end
			side_s3.fld <= fld_s2;
		end
	end

	// ---------------- stage 4: squares ----------------
	logic                  vld_s4;
	cwgf_pkg::side_t       side_s4;
	logic [2:0][2*MW-1:0]  sqr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sqr_s4[i] <= side_s3.mag[i] * side_s3.mag[i];
			end
			side_s4 <= side_s3;
		end
	end

	// ---------------- square root: one result bit per stage ----------------
	logic            vld_rt_s  [0:RW];
	logic [RW:0]     rem_rt_s  [0:RW];
	logic [RW-1:0]   root_rt_s [0:RW];
	logic [SW-1:0]   v_rt_s    [0:RW];
	cwgf_pkg::side_t side_rt_s [0:RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_rt_s[0] <= 1'b0;
		end else if (adv) begin
			vld_rt_s[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_rt_s[0]  <= '0;
			root_rt_s[0] <= '0;
			v_rt_s[0]    <= SW'(sqr_s4[0]) + SW'(sqr_s4[1]) + SW'(sqr_s4[2]);
			side_rt_s[0] <= side_s4;
		end
	end

	for (genvar k = 0; k < RW; k++) begin : g_root
		logic [RW+2:0] rp;
		logic [RW+2:0] trial;
		logic          ge;
		logic [RW+2:0] rdiff;

		always_comb begin
			rp    = {rem_rt_s[k], v_rt_s[k][SW-1:SW-2]};
			trial = {1'b0, root_rt_s[k], 2'b01};
			ge    = (rp >= trial);
			rdiff = ge ? (rp - trial) : rp;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_rt_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_rt_s[k+1] <= vld_rt_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_rt_s[k+1]  <= rdiff[RW:0];
				root_rt_s[k+1] <= {root_rt_s[k][RW-2:0], ge};
				v_rt_s[k+1]    <= {v_rt_s[k][SW-3:0], 2'b00};
				side_rt_s[k+1] <= side_rt_s[k];
			end
		end
	end

	// ---------------- dividers: unit = (mag*2^UF + s/2) / s ----------------
	logic                      vld_dv_s  [0:QW];
	logic [RW-1:0]             s_dv_s    [0:QW];
	logic [2:0][RW-1:0]        rem_dv_s  [0:QW];
	logic [2:0][QW-1:0]        n_dv_s    [0:QW];
	logic [2:0][QW-1:0]        q_dv_s    [0:QW];
	cwgf_pkg::side_t           side_dv_s [0:QW];

	logic [2:0][NUM_W-1:0] numer;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			numer[i] = NUM_W'({side_rt_s[RW].mag[i], UF'(0)})
				+ NUM_W'(root_rt_s[RW][RW-1:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dv_s[0] <= 1'b0;
		end else if (adv) begin
			vld_dv_s[0] <= vld_rt_s[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				rem_dv_s[0][i] <= RW'(numer[i][NUM_W-1:QW]);
				n_dv_s[0][i]   <= numer[i][QW-1:0];
				q_dv_s[0][i]   <= '0;
			end
			s_dv_s[0]    <= root_rt_s[RW];
			side_dv_s[0] <= side_rt_s[RW];
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [2:0][RW:0]   rp;
		logic [2:0]         ge;
		logic [2:0][RW:0]   rdiff;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rp[i]    = {rem_dv_s[k][i], n_dv_s[k][i][QW-1]};
				ge[i]    = (rp[i] >= {1'b0, s_dv_s[k]});
				rdiff[i] = ge[i] ? (rp[i] - {1'b0, s_dv_s[k]}) : rp[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_dv_s[k+1] <= vld_dv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					rem_dv_s[k+1][i] <= rdiff[i][RW-1:0];
					n_dv_s[k+1][i]   <= {n_dv_s[k][i][QW-2:0], 1'b0};
					q_dv_s[k+1][i]   <= {q_dv_s[k][i][QW-2:0], ge[i]};
				end
				s_dv_s[k+1]    <= s_dv_s[k];
				side_dv_s[k+1] <= side_dv_s[k];
			end
		end
	end

	// ---------------- stage u: signed unit normal ----------------
	logic               vld_su;
	logic               zero_su;
	logic [2:0][UW-1:0] unit_su;
	logic [5:0][FW-1:0] fld_su;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_su <= 1'b0;
		end else if (adv) begin
			vld_su <= vld_dv_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				unit_su[i] <= side_dv_s[QW].neg[i] ? (~UW'(q_dv_s[QW][i]) + UW'(1))
					: UW'(q_dv_s[QW][i]);
			end
			zero_su <= side_dv_s[QW].zero;
			fld_su  <= side_dv_s[QW].fld;
		end
	end

	// ---------------- stage p1: field times unit ----------------
	logic                 vld_sp;
	logic                 zero_sp;
	logic [2:0][UW-1:0]   unit_sp;
	logic [5:0][FW-1:0]   fld_sp;
	logic [5:0][P1_W-1:0] p1_sp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sp <= 1'b0;
		end else if (adv) begin
			vld_sp <= vld_su;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 6; j++) begin
				p1_sp[j] <= P1_W'($signed(fld_su[j]) * $signed(unit_su[j % 3]));
			end
			zero_sp <= zero_su;
			unit_sp <= unit_su;
			fld_sp  <= fld_su;
		end
	end

	// ---------------- stage d: normal components ----------------
	logic [1:0][ACC_W-1:0] acc;
	always_comb begin
		for (int g = 0; g < 2; g++) begin
			acc[g] = ACC_W'($signed(p1_sp[3*g])) + ACC_W'($signed(p1_sp[3*g+1]))
				+ ACC_W'($signed(p1_sp[3*g+2])) + (ACC_W'(1) << (UF - 1));
		end
	end

	logic                vld_sd;
	logic                zero_sd;
	logic [2:0][UW-1:0]  unit_sd;
	logic [5:0][FW-1:0]  fld_sd;
	logic [1:0][D_W-1:0] d_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd <= 1'b0;
		end else if (adv) begin
			vld_sd <= vld_sp;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_sd[0] <= acc[0][ACC_W-1:UF];
			d_sd[1] <= acc[1][ACC_W-1:UF];
			zero_sd <= zero_sp;
			unit_sd <= unit_sp;
			fld_sd  <= fld_sp;
		end
	end

	// ---------------- stage p2: twice the normal part along the unit ---------
	logic                 vld_sq;
	logic                 zero_sq;
	logic [5:0][FW-1:0]   fld_sq;
	logic [5:0][P2_W-1:0] p2_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sq <= 1'b0;
		end else if (adv) begin
			vld_sq <= vld_sd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 6; j++) begin
				p2_sq[j] <= P2_W'($signed(d_sd[j / 3]) * $signed(unit_sd[j % 3]));
			end
			zero_sq <= zero_sd;
			fld_sq  <= fld_sd;
		end
	end

	// ---------------- stage g: subtract ----------------
	logic [5:0][P2_W-1:0] p2r;
	logic [5:0][G_W-1:0]  cx;
	logic [5:0][G_W-1:0]  gsum;
	always_comb begin
		for (int j = 0; j < 6; j++) begin
			p2r[j] = p2_sq[j] + (P2_W'(1) << (UF - 2));
			cx[j]  = G_W'($signed(p2r[j][P2_W-1:UF-1]));
			if (j < 3) begin
				gsum[j] = G_W'($signed(fld_sq[j])) - cx[j];
			end else begin
				gsum[j] = cx[j] - G_W'($signed(fld_sq[j]));
			end
		end
	end

	logic                vld_sg;
	logic                zero_sg;
	logic [5:0][G_W-1:0] g_sg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sg <= 1'b0;
		end else if (adv) begin
			vld_sg <= vld_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g_sg    <= gsum;
			zero_sg <= zero_sq;
		end
	end

	// ---------------- output register: saturate ----------------
	logic [5:0][FW-1:0] sat;
	always_comb begin
		for (int j = 0; j < 6; j++) begin
			if (zero_sg) begin
				sat[j] = '0;
			end else if (g_sg[j][G_W-1:FW-1] == '0 || g_sg[j][G_W-1:FW-1] == '1) begin
				sat[j] = g_sg[j][FW-1:0];
			end else if (g_sg[j][G_W-1]) begin
				sat[j] = {1'b1, {(FW-1){1'b0}}};
			end else begin
				sat[j] = {1'b0, {(FW-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghost_valid <= 1'b0;
		end else if (adv) begin
			ghost_valid <= vld_sg;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ghost.ghost_bx    <= sat[0];
			ghost.ghost_by    <= sat[1];
			ghost.ghost_bz    <= sat[2];
			ghost.ghost_ex    <= sat[3];
			ghost.ghost_ey    <= sat[4];
			ghost.ghost_ez    <= sat[5];
			ghost.zero_normal <= zero_sg;
		end
	end

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the conducting wall ghost field unit: a directed
// table of wall faces, then random faces, predicted in bit-exact fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 75;
	localparam int N_RANDOM = 1500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic face_valid = 1'b0;
	logic face_stall;
	cwgf_pkg::face_t face = '0;
	logic ghost_valid;
	logic ghost_stall = 1'b0;
	cwgf_pkg::ghost_t ghost;

	cwgf_pkg::ghost_t ghost_q[$];
	int errors = 0;
	bit quiet = 1'b0;
	bit hold_off = 1'b0;

	always #5 clk = ~clk;

	conducting_wall_ghost_fields_unit dut (
		.clk(clk), .arst_n(arst_n),
		.face_valid(face_valid), .face_stall(face_stall), .face(face),
		.ghost_valid(ghost_valid), .ghost_stall(ghost_stall), .ghost(ghost)
	);

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [cwgf_pkg::FIELD_WIDTH-1:0] clamp(
		logic signed [127:0] g);
		if (g > 128'sd2147483647) return 32'sh7fffffff;
		if (g < -128'sd2147483648) return 32'sh80000000;
		return g[cwgf_pkg::FIELD_WIDTH-1:0];
	endfunction

	function automatic cwgf_pkg::ghost_t reflect_face(cwgf_pkg::face_t f);
		cwgf_pkg::ghost_t r;
		logic [63:0] mag[3];
		logic [63:0] big, sq, s, q;
		logic negs[3];
		logic signed [63:0] u[3];
		logic signed [63:0] n[3];
		logic signed [127:0] fv[6];
		logic signed [127:0] acc, d, c;
		n[0] = f.normal_x; n[1] = f.normal_y; n[2] = f.normal_z;
		fv[0] = f.inner_bx; fv[1] = f.inner_by; fv[2] = f.inner_bz;
		fv[3] = f.inner_ex; fv[4] = f.inner_ey; fv[5] = f.inner_ez;
		r = '0;
		big = 0;
		for (int i = 0; i < 3; i++) begin
			negs[i] = n[i] < 0;
			mag[i] = negs[i] ? -n[i] : n[i];
			if (mag[i] > big) big = mag[i];
		end
		if (big == 0) begin
			r.zero_normal = 1'b1;
			return r;
		end
		while (big >= (64'd1 << 31)) begin
			big = big >> 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
		end
		while (big < (64'd1 << 30)) begin
			big = big << 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
		end
		sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		s = isqrt(sq);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << cwgf_pkg::UNIT_FRAC) + (s >> 1)) / s;
			u[i] = negs[i] ? -$signed(q) : $signed(q);
		end
		for (int grp = 0; grp < 2; grp++) begin
			acc = 0;
			for (int i = 0; i < 3; i++) acc = acc + fv[grp * 3 + i] * u[i];
			d = (acc + (128'sd1 <<< (cwgf_pkg::UNIT_FRAC - 1))) >>> cwgf_pkg::UNIT_FRAC;
			for (int i = 0; i < 3; i++) begin
				c = (d * u[i] + (128'sd1 <<< (cwgf_pkg::UNIT_FRAC - 2)))
					>>> (cwgf_pkg::UNIT_FRAC - 1);
				case (grp * 3 + i)
					0: r.ghost_bx = clamp(fv[0] - c);
					1: r.ghost_by = clamp(fv[1] - c);
					2: r.ghost_bz = clamp(fv[2] - c);
					3: r.ghost_ex = clamp(c - fv[3]);
					4: r.ghost_ey = clamp(c - fv[4]);
					default: r.ghost_ez = clamp(c - fv[5]);
				endcase
			end
		end
		return r;
	endfunction

	// Output side: stall in bursts, or a long hold-off when asked.
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				ghost_stall <= 1'b1;
				for (k = 0; k < 300; k++) @(negedge clk);
				hold_off = 1'b0;
				ghost_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				ghost_stall <= 1'b1;
				k = $urandom_range(1, 5);
				repeat (k - 1) @(negedge clk);
				@(negedge clk);
				ghost_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && ghost_valid && !ghost_stall) begin
			if (ghost_q.size() == 0) begin
				$error("unexpected result %h", ghost);
				errors++;
			end else begin
				cwgf_pkg::ghost_t e;
				e = ghost_q.pop_front();
				if (ghost.ghost_bx !== e.ghost_bx) begin
					$error("ghost_bx exp %h got %h", e.ghost_bx, ghost.ghost_bx); errors++;
				end
				if (ghost.ghost_by !== e.ghost_by) begin
					$error("ghost_by exp %h got %h", e.ghost_by, ghost.ghost_by); errors++;
				end
				if (ghost.ghost_bz !== e.ghost_bz) begin
					$error("ghost_bz exp %h got %h", e.ghost_bz, ghost.ghost_bz); errors++;
				end
				if (ghost.ghost_ex !== e.ghost_ex) begin
					$error("ghost_ex exp %h got %h", e.ghost_ex, ghost.ghost_ex); errors++;
				end
				if (ghost.ghost_ey !== e.ghost_ey) begin
					$error("ghost_ey exp %h got %h", e.ghost_ey, ghost.ghost_ey); errors++;
				end
				if (ghost.ghost_ez !== e.ghost_ez) begin
					$error("ghost_ez exp %h got %h", e.ghost_ez, ghost.ghost_ez); errors++;
				end
				if (ghost.zero_normal !== e.zero_normal) begin
					$error("zero_normal exp %b got %b", e.zero_normal, ghost.zero_normal);
					errors++;
				end
			end
		end
	end

	// Present one request; hold it until taken. Optional gap first.
	task automatic send_face(cwgf_pkg::face_t f, cwgf_pkg::ghost_t exp_r);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			face_valid <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(negedge clk);
		end
		face <= f;
		face_valid <= 1'b1;
		@(posedge clk);
		while (face_stall) @(posedge clk);
		ghost_q.push_back(exp_r);
		@(negedge clk);
	endtask

	function automatic cwgf_pkg::face_t rand_face(int mode);
		cwgf_pkg::face_t f;
		f = cwgf_pkg::face_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom});
		case (mode)
			0: begin
				f.normal_x = $signed(24'($urandom_range(0, 7))) - 24'sd3;
				f.normal_y = $signed(24'($urandom_range(0, 7))) - 24'sd3;
				f.normal_z = $signed(24'($urandom_range(0, 7))) - 24'sd3;
			end
			1: begin
				f.inner_bx = $signed(f.inner_bx) >>> $urandom_range(0, 24);
				f.inner_by = $signed(f.inner_by) >>> $urandom_range(0, 24);
				f.inner_bz = $signed(f.inner_bz) >>> $urandom_range(0, 24);
				f.inner_ex = $signed(f.inner_ex) >>> $urandom_range(0, 24);
				f.inner_ey = $signed(f.inner_ey) >>> $urandom_range(0, 24);
				f.inner_ez = $signed(f.inner_ez) >>> $urandom_range(0, 24);
			end
			2: begin
				f.normal_y = '0;
				f.normal_z = '0;
			end
			default: ;
		endcase
		return f;
	endfunction

	typedef struct {
		cwgf_pkg::face_t  f;
		bit               typed;
		cwgf_pkg::ghost_t r;
	} face_row_t;

	initial begin
		face_row_t rows[$];
		face_row_t row;
		cwgf_pkg::face_t f;
		cwgf_pkg::ghost_t zr;
		int wait_cycles;
		zr = '0;
		zr.zero_normal = 1'b1;

		// zero normal: flag set, outputs zero
		row.f = '0; row.typed = 1; row.r = zr; rows.push_back(row);
		row.f = {72'd0, {6{32'sh7fffffff}}}; rows.push_back(row);
		row.f = {72'd0, {6{32'sh80000000}}}; rows.push_back(row);
		// axis normal, zero fields
		row.f = '0; row.f.normal_z = 24'sd1; row.r = '0; rows.push_back(row);
		row.typed = 0;
		row.f = {24'sh7fffff, 24'sh7fffff, 24'sh7fffff, {6{32'sh7fffffff}}}; rows.push_back(row);
		row.f = {24'sh800000, 24'sh800000, 24'sh800000, {6{32'sh80000000}}}; rows.push_back(row);
		row.f = {24'sh800000, 24'sd0, 24'sd0, {6{32'sh80000000}}}; rows.push_back(row);
		row.f = {24'sd0, 24'sh7fffff, 24'sd0, {6{32'sh7fffffff}}}; rows.push_back(row);
		row.f = {24'sd1, 24'sd0, 24'sd0, 32'sh00010000, 32'sh00020000, 32'sh00030000,
			32'sh00010000, 32'sh00020000, 32'sh00030000}; rows.push_back(row);
		row.f = {24'sd0, 24'shffffff, 24'sd0, {3{32'sh40000000}}, {3{32'shc0000000}}};
		rows.push_back(row);
		row.f = {24'sd3, 24'sd4, 24'sd0, {6{32'sh00000001}}}; rows.push_back(row);
		row.f = {24'sh800000, 24'sh7fffff, 24'sd1, {6{32'shffffffff}}}; rows.push_back(row);
		row.f = {24'sd1, 24'sd1, 24'sd1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000}; rows.push_back(row);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i])
			send_face(rows[i].f, rows[i].typed ? rows[i].r : reflect_face(rows[i].f));

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 400) hold_off = 1'b1;
			if (n == N_RANDOM - 200) quiet = 1'b1;
			f = rand_face($urandom_range(0, 4));
			if ($urandom_range(0, 60) == 0) begin
				f.normal_x = '0; f.normal_y = '0; f.normal_z = '0;
			end
			send_face(f, reflect_face(f));
		end
		face_valid <= 1'b0;

		wait_cycles = 0;
		while (ghost_q.size() != 0 && wait_cycles < 100000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 10) @(negedge clk);
		if (errors == 0 && ghost_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
